### sv/cvu_pkg.sv
// Package for the candidate vote/union block: sizes, field widths,
// command codes and the controller/datapath command and status structs.
// No dependencies.
package cvu_pkg;

    localparam int unsigned PROTO_COUNT = 65536;
    localparam int unsigned LIST_CAP    = 1024;

    localparam int unsigned PROTO_AW = $clog2(PROTO_COUNT);
    localparam int unsigned LIST_AW  = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
    localparam int unsigned CNT_W    = $clog2(LIST_CAP + 1);

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned IDX_W   = 16;
    localparam int unsigned VOTE_W  = 16;
    localparam int unsigned SIZE_W  = 11;
    localparam int unsigned HITS_W  = 16;
    localparam int unsigned LIMIT_W = 11;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic               REG_UNION_LIMIT = 1'b0;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HIT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic init_we;
        logic accept;
        logic clear_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic in_hit;
        logic in_clear;
        logic clear_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

### sv/cvu_cand_if.sv
// Candidate input channel: valid/ready handshake with command and index.
// Depends on cvu_pkg.
interface cvu_cand_if;
    import cvu_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   proto_index;

    modport source (output valid, command, proto_index, input ready);
    modport sink   (input valid, command, proto_index, output ready);
endinterface

### sv/cvu_result_if.sv
// Result output channel: valid/ready handshake with status and counters.
// Depends on cvu_pkg.
interface cvu_result_if;
    import cvu_pkg::*;

    logic               valid;
    logic               ready;
    logic               stop;
    logic               added_new;
    logic [VOTE_W-1:0]  vote_after;
    logic [SIZE_W-1:0]  union_size;
    logic [HITS_W-1:0]  table_hits;

    modport source (output valid, stop, added_new, vote_after, union_size, table_hits,
                    input ready);
    modport sink   (input valid, stop, added_new, vote_after, union_size, table_hits,
                    output ready);
endinterface

### sv/cvu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cvu_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/cvu_ctrl.sv
// Controller for the vote/union block: reset sweep, hit read/commit,
// clear walk and result hand-off. Depends on cvu_pkg.
module cvu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cand_valid,
    output logic               cand_ready,
    input  cvu_pkg::ctrl_sts_t sts,
    output cvu_pkg::ctrl_cmd_t cmd
);
    import cvu_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_HIT,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cand_ready     = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_we = 1'b1;
                if (sts.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cand_ready = 1'b1;
                if (cand_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_clear)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (sts.in_hit)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_HIT;
            end
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.clear_step = 1'b1;
                end
            end
            ST_HIT, ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

### sv/cvu_dp.sv
// Datapath for the vote/union block: vote store, touched list, counters
// and result register. Depends on cvu_pkg and cvu_ram.
module cvu_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cvu_pkg::CMD_W-1:0]   command,
    input  logic [cvu_pkg::IDX_W-1:0]   proto_index,
    input  logic [cvu_pkg::LIMIT_W-1:0] limit,
    input  cvu_pkg::ctrl_cmd_t          cmd,
    output cvu_pkg::ctrl_sts_t          sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        stop,
    output logic                        added_new,
    output logic [cvu_pkg::VOTE_W-1:0]  vote_after,
    output logic [cvu_pkg::SIZE_W-1:0]  union_size,
    output logic [cvu_pkg::HITS_W-1:0]  table_hits
);
    import cvu_pkg::*;

    logic [CMD_W-1:0]    cmd_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                hit_reg;
    logic [PROTO_AW-1:0] init_reg;
    logic [CNT_W-1:0]    walk_reg;
    logic                wv_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [HITS_W-1:0]   hits_reg;

    logic                out_valid_reg;
    logic                stop_reg;
    logic                added_reg;
    logic [VOTE_W-1:0]   vote_out_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [HITS_W-1:0]   hits_out_reg;

    logic [31:0]         in_idx32;
    logic [31:0]         idx32;
    logic [31:0]         list32;
    logic [31:0]         lim32;
    logic [31:0]         cnt32;
    logic [31:0]         cnt_after32;
    logic [31:0]         walk32;
    logic                full;
    logic                vote_zero;
    logic                refuse;
    logic                add;
    logic                bump;
    logic [VOTE_W-1:0]   vote_rd;
    logic [VOTE_W-1:0]   vote_inc;
    logic [IDX_W-1:0]    list_rd;
    logic [CNT_W-1:0]    count_next;
    logic [HITS_W-1:0]   hits_next;

    logic                vote_we;
    logic [PROTO_AW-1:0] vote_waddr;
    logic [VOTE_W-1:0]   vote_wdata;

    assign in_idx32 = 32'(proto_index);
    assign idx32    = 32'(idx_reg);
    assign list32   = 32'(list_rd);
    assign cnt32    = 32'(count_reg);
    assign walk32   = 32'(walk_reg);
    assign lim32    = (32'(limit) > LIST_CAP) ? LIST_CAP : 32'(limit);

    assign full      = cnt32 >= lim32;
    assign vote_zero = vote_rd == '0;
    assign refuse    = hit_reg && vote_zero && full;
    assign add       = hit_reg && vote_zero && !full;
    assign bump      = hit_reg && !refuse;
    assign vote_inc  = vote_rd + VOTE_W'(1);

    always_comb
    begin
        count_next = count_reg;
        hits_next  = hits_reg;
        if (cmd_reg == CMD_CLEAR)
        begin
            count_next = '0;
        end
        else if (add)
        begin
            count_next = CNT_W'(cnt32 + 32'd1);
        end
        if (cmd_reg == CMD_START)
        begin
            hits_next = '0;
        end
        else if (bump && hits_reg != '1)
        begin
            hits_next = hits_reg + HITS_W'(1);
        end
    end

    assign cnt_after32 = 32'(count_next);

    always_comb
    begin
        vote_we    = 1'b0;
        vote_waddr = idx32[PROTO_AW-1:0];
        vote_wdata = '0;
        if (cmd.init_we)
        begin
            vote_we    = 1'b1;
            vote_waddr = init_reg;
        end
        else if (wv_reg)
        begin
            vote_we    = 1'b1;
            vote_waddr = list32[PROTO_AW-1:0];
        end
        else if (cmd.commit && bump)
        begin
            vote_we    = 1'b1;
            vote_wdata = vote_inc;
        end
    end

    cvu_ram #(
        .WIDTH (VOTE_W),
        .DEPTH (PROTO_COUNT)
    ) u_vote_ram (
        .clk   (clk),
        .we    (vote_we),
        .waddr (vote_waddr),
        .wdata (vote_wdata),
        .raddr (idx32[PROTO_AW-1:0]),
        .rdata (vote_rd)
    );

    cvu_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LIST_CAP)
    ) u_list_ram (
        .clk   (clk),
        .we    (cmd.commit && add),
        .waddr (count_reg[LIST_AW-1:0]),
        .wdata (idx_reg),
        .raddr (walk_reg[LIST_AW-1:0]),
        .rdata (list_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= '0;
            walk_reg      <= '0;
            wv_reg        <= 1'b0;
            count_reg     <= '0;
            hits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_we)
            begin
                init_reg <= init_reg + PROTO_AW'(1);
            end
            if (cmd.accept)
            begin
                walk_reg <= '0;
                wv_reg   <= 1'b0;
            end
            else if (cmd.clear_step)
            begin
                wv_reg <= walk32 < cnt32;
                if (walk32 < cnt32)
                begin
                    walk_reg <= walk_reg + CNT_W'(1);
                end
            end
            else
            begin
                wv_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                hits_reg      <= hits_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg <= command;
            idx_reg <= proto_index;
            hit_reg <= (command == CMD_HIT) && (in_idx32 < PROTO_COUNT);
        end
        if (cmd.commit)
        begin
            stop_reg     <= refuse || (cnt_after32 >= lim32);
            added_reg    <= add;
            vote_out_reg <= bump ? vote_inc : '0;
            size_reg     <= cnt_after32[SIZE_W-1:0];
            hits_out_reg <= hits_next;
        end
    end

    assign sts.init_last  = init_reg == PROTO_AW'(PROTO_COUNT - 1);
    assign sts.in_hit     = (command == CMD_HIT) && (in_idx32 < PROTO_COUNT);
    assign sts.in_clear   = command == CMD_CLEAR;
    assign sts.clear_done = (walk32 >= cnt32) && !wv_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign stop       = stop_reg;
    assign added_new  = added_reg;
    assign vote_after = vote_out_reg;
    assign union_size = size_reg;
    assign table_hits = hits_out_reg;

endmodule

### sv/candidate_vote_union_core.sv
// Candidate vote/union core: APB limit register, controller and datapath.
// Depends on cvu_pkg, cvu_cand_if, cvu_result_if, cvu_ctrl, cvu_dp.
// Hit: vote RAM read, then commit. Start-table and no-op: commit only. Clear
// walks the list one entry a cycle, then commits.
// One item in flight at a time.
// Reset: async active low; then a sweep zeroes the vote RAM, no transaction
// accepted meanwhile (APB writes still taken).
module candidate_vote_union_core (
    input  logic                        clk,
    input  logic                        rst_n,
    cvu_cand_if.sink                    cand,
    cvu_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cvu_pkg::PADDR_W-1:0] paddr,
    input  logic [cvu_pkg::PDATA_W-1:0] pwdata,
    output logic [cvu_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cvu_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    ctrl_cmd_t          ctrl_cmd;
    ctrl_sts_t          ctrl_sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_UNION_LIMIT)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UNION_LIMIT) ? PDATA_W'(limit_reg) : '0;

    cvu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand.valid),
        .cand_ready (cand.ready),
        .sts        (ctrl_sts),
        .cmd        (ctrl_cmd)
    );

    cvu_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (cand.command),
        .proto_index (cand.proto_index),
        .limit       (limit_reg),
        .cmd         (ctrl_cmd),
        .sts         (ctrl_sts),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .stop        (result.stop),
        .added_new   (result.added_new),
        .vote_after  (result.vote_after),
        .union_size  (result.union_size),
        .table_hits  (result.table_hits)
    );

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_cmd.init_we || ctrl_cmd.clear_step) |-> !cand.ready)
        else $error("candidate ready during sweep or clear walk");

    a_new_vote_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.added_new) |-> (result.vote_after == 16'd1))
        else $error("new union entry without a first vote");

    a_new_size: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.added_new) |-> (result.union_size != '0))
        else $error("new union entry with empty union");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |-> (!result.valid || result.ready))
        else $error("result overwritten before transaction");

endmodule

### bench/candidate_vote_union_core_tb.sv
// Testbench for candidate_vote_union_core: drives candidate transactions and
// union_limit writes, predicts each result in step and checks it field by field.
// Depends on cvu_pkg, cvu_cand_if, cvu_result_if and the core RTL.
`timescale 1ns / 100ps

module candidate_vote_union_core_tb;
    import cvu_pkg::*;

    typedef struct packed {
        logic               stop;
        logic               added_new;
        logic [VOTE_W-1:0]  vote_after;
        logic [SIZE_W-1:0]  union_size;
        logic [HITS_W-1:0]  table_hits;
    } union_status_t;

    localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * int'(REG_UNION_LIMIT));

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cvu_cand_if   cand_ch ();
    cvu_result_if res_ch ();

    candidate_vote_union_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cand    (cand_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted block state
    bit [VOTE_W-1:0]    vote_mem [PROTO_COUNT];
    bit [IDX_W-1:0]     touched_protos [$];
    int unsigned        touched_cnt;
    int unsigned        table_hit_cnt;
    int unsigned        limit_reg;

    union_status_t      pending_results [$];
    int                 fail_count;
    bit                 no_idle;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("candidate_vote_union_core test failed");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic union_status_t predict_union_step(input logic [CMD_W-1:0] cmd,
                                                         input logic [IDX_W-1:0] idx);
        union_status_t res;
        int unsigned   eff;
        eff = (limit_reg > LIST_CAP) ? LIST_CAP : limit_reg;
        res = '0;
        case (cmd)
            CMD_CLEAR:
            begin
                foreach (touched_protos[j])
                    vote_mem[touched_protos[j]] = '0;
                touched_protos.delete();
                touched_cnt = 0;
            end
            CMD_START:
                table_hit_cnt = 0;
            CMD_HIT:
            begin
                if (vote_mem[idx] == 0)
                begin
                    if (touched_cnt >= eff || touched_cnt >= LIST_CAP)
                    begin
                        res.stop       = 1'b1;
                        res.union_size = SIZE_W'(touched_cnt);
                        res.table_hits = HITS_W'(table_hit_cnt);
                        return res;
                    end
                    touched_protos.push_back(idx);
                    touched_cnt++;
                    res.added_new = 1'b1;
                end
                vote_mem[idx]  = vote_mem[idx] + 1'b1;
                res.vote_after = vote_mem[idx];
                if (table_hit_cnt < 65535)
                    table_hit_cnt++;
            end
            default:
                ;
        endcase
        res.stop       = (touched_cnt >= eff);
        res.union_size = SIZE_W'(touched_cnt);
        res.table_hits = HITS_W'(table_hit_cnt);
        return res;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            cand_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cand_ch.valid       <= 1'b1;
        cand_ch.command     <= cmd;
        cand_ch.proto_index <= idx;
        @(posedge clk);
        while (!cand_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_union_step(cmd, idx));
    endtask

    task automatic wait_drained();
        cand_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_reg = value;
    endtask

    // result side: random stalls, compare against oldest prediction
    initial
    begin
        int            stall;
        union_status_t exp_res;
        res_ch.ready <= 1'b0;
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (res_ch.stop !== exp_res.stop)
                begin
                    $error("stop: expected %0d, got %0d", exp_res.stop, res_ch.stop);
                    fail_count++;
                end
                if (res_ch.added_new !== exp_res.added_new)
                begin
                    $error("added_new: expected %0d, got %0d",
                           exp_res.added_new, res_ch.added_new);
                    fail_count++;
                end
                if (res_ch.vote_after !== exp_res.vote_after)
                begin
                    $error("vote_after: expected %0d, got %0d",
                           exp_res.vote_after, res_ch.vote_after);
                    fail_count++;
                end
                if (res_ch.union_size !== exp_res.union_size)
                begin
                    $error("union_size: expected %0d, got %0d",
                           exp_res.union_size, res_ch.union_size);
                    fail_count++;
                end
                if (res_ch.table_hits !== exp_res.table_hits)
                begin
                    $error("table_hits: expected %0d, got %0d",
                           exp_res.table_hits, res_ch.table_hits);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_idle_status();
        send_item(CMD_NOP, 16'h0000);
        send_item(CMD_START, 16'hFFFF);
        send_item(CMD_CLEAR, 16'h0000);
    endtask

    task automatic test_directed_hits();
        send_item(CMD_HIT, 16'h0000);
        send_item(CMD_HIT, 16'hFFFF);
        send_item(CMD_HIT, 16'h5555);
        send_item(CMD_HIT, 16'hAAAA);
        send_item(CMD_HIT, 16'h0000);
        send_item(CMD_HIT, 16'h0000);
        send_item(CMD_START, 16'h0000);
        send_item(CMD_HIT, 16'hFFFF);
        send_item(CMD_NOP, 16'hFFFF);
        send_item(CMD_CLEAR, 16'h0000);
        send_item(CMD_HIT, 16'h0000);
        send_item(CMD_CLEAR, 16'h0000);
    endtask

    task automatic test_limit_edges();
        write_limit(11'd1);
        send_item(CMD_HIT, 16'h1111);
        send_item(CMD_HIT, 16'h1111);
        send_item(CMD_HIT, 16'h2222);       // refused, list full
        write_limit(11'd0);
        send_item(CMD_HIT, 16'h1111);       // already listed, still counts
        send_item(CMD_HIT, 16'h3333);
        send_item(CMD_CLEAR, 16'h0000);     // stop stays high at limit zero
        send_item(CMD_HIT, 16'h3333);
        write_limit(11'd2047);
        send_item(CMD_HIT, 16'h4444);
        send_item(CMD_HIT, 16'h5555);
        send_item(CMD_HIT, 16'h6666);
        write_limit(11'd2);                 // below current count
        send_item(CMD_NOP, 16'h0000);
        send_item(CMD_HIT, 16'h4444);
        send_item(CMD_HIT, 16'h7777);
        send_item(CMD_CLEAR, 16'h0000);
    endtask

    task automatic test_list_capacity();
        write_limit(11'd256);
        send_item(CMD_CLEAR, 16'h0000);
        for (int j = 0; j <= 256; j++)
            send_item(CMD_HIT, IDX_W'(j * 61 + 7));
        send_item(CMD_NOP, 16'h0000);
        send_item(CMD_CLEAR, 16'h0000);
        send_item(CMD_START, 16'h0000);
    endtask

    task automatic test_random_traffic();
        logic [IDX_W-1:0]   pool [16];
        logic [LIMIT_W-1:0] lim;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        int                 r;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: lim = 11'd1024;
                1: lim = 11'd1;
                2: lim = 11'd7;
                3: lim = 11'd0;
                4: lim = 11'd2047;
                5: lim = LIMIT_W'($urandom_range(1, 64));
                6: lim = 11'd300;
                default: lim = 11'd1024;
            endcase
            write_limit(lim);
            foreach (pool[k])
                pool[k] = IDX_W'($urandom);
            no_idle = (p == 5);
            for (int n = 0; n < 50; n++)
            begin
                if (p == 2 && n == 25)
                    wait_drained();
                r = $urandom_range(0, 99);
                if (r < 6)
                    cmd = CMD_CLEAR;
                else if (r < 12)
                    cmd = CMD_START;
                else if (r < 16)
                    cmd = CMD_NOP;
                else
                    cmd = CMD_HIT;
                if ($urandom_range(0, 3) == 0)
                    idx = IDX_W'($urandom);
                else
                    idx = pool[$urandom_range(0, 15)];
                send_item(cmd, idx);
            end
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        fail_count = 0;
        no_idle    = 1'b0;
        touched_cnt   = 0;
        table_hit_cnt = 0;
        limit_reg     = LIMIT_RESET;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cand_ch.valid       <= 1'b0;
        cand_ch.command     <= CMD_NOP;
        cand_ch.proto_index <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_status();
        test_directed_hits();
        test_limit_edges();
        test_list_capacity();
        test_random_traffic();

        wait_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("candidate_vote_union_core test passed");
        else
            $display("candidate_vote_union_core test failed");
        $finish;
    end

endmodule
